// ===== hdl/bpfa_pkg.sv =====
package bpfa_pkg;

  // Fixed port widths
  localparam int ADDR_W = 48;
  localparam int CNT_W  = 13;

  // Bitmap storage: one word per memory row, scanned a chunk at a time
  localparam int LOG_WORD   = 6;
  localparam int WORD_BITS  = 1 << LOG_WORD;
  localparam int LOG_CHUNK  = 3;
  localparam int CHUNK_BITS = 1 << LOG_CHUNK;
  localparam int CHUNK_IW   = LOG_WORD - LOG_CHUNK;
  localparam int CHUNKS     = 1 << CHUNK_IW;

  // Request kinds
  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_FREE    = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;

  // Result status
  localparam logic [1:0] STAT_DONE = 2'd0;
  localparam logic [1:0] STAT_FAIL = 2'd1;
  localparam logic [1:0] STAT_IGN  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_BASE  = 1'b0;
  localparam logic CFG_PAGES = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LIMIT,
    ST_AL_CHK,
    ST_AL_RD,
    ST_AL_SCAN,
    ST_AL_FOUND,
    ST_AL_MUL,
    ST_AL_ADD,
    ST_RW_INIT,
    ST_RW_RD,
    ST_RW_WR,
    ST_FR_OFF,
    ST_FR_CHK,
    ST_FR_DIV,
    ST_RL_END,
    ST_RL_OFF,
    ST_RL_CLAMP,
    ST_RL_EMPTY,
    ST_RL_DIV1,
    ST_RL_LEN,
    ST_RL_DIV2,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// ===== hdl/bpfa_ram.sv =====
module bpfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                          clk_i,
  input  logic                                          wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                              wr_data_i,
  input  logic                                          rd_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                              rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/bpfa_div.sv =====
// Page number from a byte offset: a shift by the page size, which is a power of two.
// The quotient is registered and flagged done on the cycle after start.
module bpfa_div #(
  parameter int DW      = 26,
  parameter int QW      = 13,
  parameter int DIVISOR = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DW-1:0]      dividend_i,
  output logic [QW-1:0]      quot_o,
  output bpfa_pkg::div_sts_t sts_o
);

  localparam int SH = $clog2(DIVISOR);

  logic          done_q, done_d;
  logic [QW-1:0] quot_q, quot_d;

  always_comb begin
    done_d = start_i;
    quot_d = quot_q;
    if (start_i) begin
      quot_d = QW'(dividend_i >> SH);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
  end

  assign quot_o     = quot_q;
  assign sts_o.busy = 1'b0;
  assign sts_o.done = done_q;

endmodule

// ===== hdl/bitmap_page_frame_allocator_top.sv =====
// Page numbers come from a registered shift by the page size (a power of two).
// One request at a time; the single bitmap memory and the chunk scanner (8 pages a
// cycle while scanning a word) set the allocate time. A finished result waits in an output register.
// After reset the bitmap is cleared one word at a time, ceil(MAX_PAGES/64) words (64 by default).
module bitmap_page_frame_allocator_top #(
  parameter int MAX_PAGES  = 4096,
  parameter int PAGE_BYTES = 4096,
  parameter int ADDR_BITS  = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [bpfa_pkg::ADDR_W-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    req_type_i,
  input  logic [bpfa_pkg::CNT_W-1:0]    page_count_i,
  input  logic [bpfa_pkg::ADDR_W-1:0]   address_i,
  input  logic [bpfa_pkg::ADDR_W-1:0]   region_length_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bpfa_pkg::ADDR_W-1:0]   result_address_o,
  output logic [1:0]                    status_o
);

  localparam int AW  = ADDR_BITS;
  localparam int EW  = (AW > bpfa_pkg::ADDR_W) ? AW : bpfa_pkg::ADDR_W;
  localparam int SW  = EW + 1;
  localparam int QW  = $clog2(MAX_PAGES + 1);
  localparam int PBW = $clog2(PAGE_BYTES + 1);
  localparam int DW  = QW + PBW;
  localparam int XW  = (AW > DW) ? AW : DW;
  localparam int TW  = (QW > bpfa_pkg::CNT_W) ? QW : bpfa_pkg::CNT_W;
  localparam int MAP_WORDS = (MAX_PAGES + bpfa_pkg::WORD_BITS - 1) / bpfa_pkg::WORD_BITS;
  localparam int WAW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PGW = WAW + bpfa_pkg::LOG_WORD + 1;
  localparam int PWW = WAW + 1;
  localparam int WB  = bpfa_pkg::WORD_BITS;
  localparam int LW  = bpfa_pkg::LOG_WORD;

  bpfa_pkg::state_e state_q, state_d;

  logic [WAW-1:0]                 clr_q, clr_d;
  logic [AW-1:0]                  base_q, base_d;
  logic [bpfa_pkg::CNT_W-1:0]     pages_q, pages_d;
  logic [1:0]                     req_q, req_d;
  logic [bpfa_pkg::CNT_W-1:0]     count_q, count_d;
  logic [AW-1:0]                  addr_q, addr_d;
  logic [bpfa_pkg::ADDR_W-1:0]    len_q, len_d;
  logic [QW-1:0]                  total_q, total_d;
  logic [DW-1:0]                  limit_q, limit_d;
  logic [WAW-1:0]                 word_q, word_d;
  logic [bpfa_pkg::CHUNK_IW-1:0]  chunk_q, chunk_d;
  logic [QW-1:0]                  run_q, run_d;
  logic [PGW-1:0]                 hit_q, hit_d;
  logic [PGW-1:0]                 lo_q, lo_d;
  logic [PGW-1:0]                 hi_q, hi_d;
  logic                           set_q, set_d;
  logic [WAW-1:0]                 rw_word_q, rw_word_d;
  logic [AW-1:0]                  end_q, end_d;
  logic [AW-1:0]                  soff_q, soff_d;
  logic [XW-1:0]                  eoff_q, eoff_d;
  logic [DW-1:0]                  prod_q, prod_d;
  logic [AW-1:0]                  res_q, res_d;
  logic [1:0]                     stat_q, stat_d;
  logic                           out_valid_q, out_valid_d;
  logic [bpfa_pkg::ADDR_W-1:0]    out_addr_q, out_addr_d;
  logic [1:0]                     out_stat_q, out_stat_d;

  // bitmap memory
  logic           ram_we, ram_re;
  logic [WAW-1:0] ram_waddr, ram_raddr;
  logic [WB-1:0]  ram_wdata, ram_rdata;

  // shared page-number unit
  logic               div_start;
  logic [DW-1:0]      div_dividend;
  logic [QW-1:0]      div_quot;
  bpfa_pkg::div_sts_t div_sts;

  // decisions
  logic [QW-1:0]  count_w;
  logic           accept, out_free;
  logic           al_bad, fr_bad, fr_out, rl_none, rl_empty;
  logic [SW-1:0]  rl_sum;

  // chunk scanner
  logic [bpfa_pkg::CHUNK_BITS-1:0] chunk_bits;
  logic [PGW-1:0]                  chunk_base;
  logic [QW-1:0]                   s_run;
  logic                            s_hit, s_last;
  logic [PGW-1:0]                  s_hitp;

  // range writer
  logic [PWW-1:0] cur_x, lo_x, hi_x, last_x;
  logic [PGW-1:0] hi_m1;
  logic [LW-1:0]  lo_off;
  logic [LW:0]    hi_off;
  logic [WB-1:0]  mask, wr_merge;
  logic           rw_last;

  bpfa_ram #(
    .WIDTH(WB),
    .DEPTH(MAP_WORDS)
  ) u_map (
    .clk_i    (clk_i),
    .wr_en_i  (ram_we),
    .wr_addr_i(ram_waddr),
    .wr_data_i(ram_wdata),
    .rd_en_i  (ram_re),
    .rd_addr_i(ram_raddr),
    .rd_data_o(ram_rdata)
  );

  bpfa_div #(
    .DW     (DW),
    .QW     (QW),
    .DIVISOR(PAGE_BYTES)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .quot_o    (div_quot),
    .sts_o     (div_sts)
  );

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign count_w  = QW'(count_q);

  assign al_bad   = (count_q == '0) || (TW'(count_q) > TW'(total_q));
  assign fr_bad   = (addr_q == '0) || (addr_q < base_q);
  assign fr_out   = (XW'(soff_q) >= XW'(limit_q));
  assign rl_sum   = SW'(addr_q) + SW'(len_q);
  assign rl_none  = (end_q <= base_q);
  assign rl_empty = (XW'(soff_q) >= eoff_q);

  // Scan eight pages of the current word; the run carries across chunks.
  assign chunk_bits = ram_rdata[chunk_q * bpfa_pkg::CHUNK_BITS +: bpfa_pkg::CHUNK_BITS];
  assign chunk_base = PGW'({word_q, chunk_q, {bpfa_pkg::LOG_CHUNK{1'b0}}});
  assign s_last     = (chunk_base + PGW'(bpfa_pkg::CHUNK_BITS)) >= PGW'(total_q);

  always_comb begin
    logic [PGW-1:0] pg;
    s_run  = run_q;
    s_hit  = 1'b0;
    s_hitp = '0;
    pg     = '0;
    for (int k = 0; k < bpfa_pkg::CHUNK_BITS; k++) begin
      pg = chunk_base + PGW'(k);
      if (!s_hit) begin
        if (chunk_bits[k] && (pg < PGW'(total_q))) begin
          s_run = s_run + 1'b1;
          if (s_run == count_w) begin
            s_hit  = 1'b1;
            s_hitp = pg;
          end
        end else begin
          s_run = '0;
        end
      end
    end
  end

  // Word mask for pages lo_q .. hi_q-1
  assign hi_m1    = hi_q - 1'b1;
  assign cur_x    = {1'b0, rw_word_q};
  assign lo_x     = lo_q[PGW-1:LW];
  assign hi_x     = hi_q[PGW-1:LW];
  assign last_x   = hi_m1[PGW-1:LW];
  assign lo_off   = (cur_x == lo_x) ? lo_q[LW-1:0] : '0;
  assign hi_off   = (cur_x == hi_x) ? {1'b0, hi_q[LW-1:0]} : (LW + 1)'(WB);
  assign mask     = ({WB{1'b1}} << lo_off) & ~({WB{1'b1}} << hi_off);
  assign wr_merge = set_q ? (ram_rdata | mask) : (ram_rdata & ~mask);
  assign rw_last  = (cur_x == last_x);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bpfa_pkg::ST_CLEAR: begin
        if (clr_q == WAW'(MAP_WORDS - 1)) begin
          state_d = bpfa_pkg::ST_IDLE;
        end
      end
      bpfa_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = bpfa_pkg::ST_LIMIT;
        end
      end
      bpfa_pkg::ST_LIMIT: begin
        case (req_q)
          bpfa_pkg::REQ_ALLOC:   state_d = bpfa_pkg::ST_AL_CHK;
          bpfa_pkg::REQ_FREE:    state_d = bpfa_pkg::ST_FR_OFF;
          bpfa_pkg::REQ_RELEASE: state_d = bpfa_pkg::ST_RL_END;
          default:               state_d = bpfa_pkg::ST_FINISH;
        endcase
      end
      bpfa_pkg::ST_AL_CHK: begin
        state_d = al_bad ? bpfa_pkg::ST_FINISH : bpfa_pkg::ST_AL_RD;
      end
      bpfa_pkg::ST_AL_RD: state_d = bpfa_pkg::ST_AL_SCAN;
      bpfa_pkg::ST_AL_SCAN: begin
        if (s_hit) begin
          state_d = bpfa_pkg::ST_AL_FOUND;
        end else if (s_last) begin
          state_d = bpfa_pkg::ST_FINISH;
        end else if (chunk_q == bpfa_pkg::CHUNK_IW'(bpfa_pkg::CHUNKS - 1)) begin
          state_d = bpfa_pkg::ST_AL_RD;
        end
      end
      bpfa_pkg::ST_AL_FOUND: state_d = bpfa_pkg::ST_RW_INIT;
      bpfa_pkg::ST_RW_INIT:  state_d = bpfa_pkg::ST_RW_RD;
      bpfa_pkg::ST_RW_RD:    state_d = bpfa_pkg::ST_RW_WR;
      bpfa_pkg::ST_RW_WR: begin
        if (!rw_last) begin
          state_d = bpfa_pkg::ST_RW_RD;
        end else if (req_q == bpfa_pkg::REQ_ALLOC) begin
          state_d = bpfa_pkg::ST_AL_MUL;
        end else begin
          state_d = bpfa_pkg::ST_FINISH;
        end
      end
      bpfa_pkg::ST_AL_MUL: state_d = bpfa_pkg::ST_AL_ADD;
      bpfa_pkg::ST_AL_ADD: state_d = bpfa_pkg::ST_FINISH;
      bpfa_pkg::ST_FR_OFF: begin
        state_d = fr_bad ? bpfa_pkg::ST_FINISH : bpfa_pkg::ST_FR_CHK;
      end
      bpfa_pkg::ST_FR_CHK: begin
        state_d = fr_out ? bpfa_pkg::ST_FINISH : bpfa_pkg::ST_FR_DIV;
      end
      bpfa_pkg::ST_FR_DIV: begin
        if (div_sts.done) begin
          state_d = bpfa_pkg::ST_RW_INIT;
        end
      end
      bpfa_pkg::ST_RL_END: state_d = bpfa_pkg::ST_RL_OFF;
      bpfa_pkg::ST_RL_OFF: begin
        state_d = rl_none ? bpfa_pkg::ST_FINISH : bpfa_pkg::ST_RL_CLAMP;
      end
      bpfa_pkg::ST_RL_CLAMP: state_d = bpfa_pkg::ST_RL_EMPTY;
      bpfa_pkg::ST_RL_EMPTY: begin
        state_d = rl_empty ? bpfa_pkg::ST_FINISH : bpfa_pkg::ST_RL_DIV1;
      end
      bpfa_pkg::ST_RL_DIV1: begin
        if (div_sts.done) begin
          state_d = bpfa_pkg::ST_RL_LEN;
        end
      end
      bpfa_pkg::ST_RL_LEN: state_d = bpfa_pkg::ST_RL_DIV2;
      bpfa_pkg::ST_RL_DIV2: begin
        if (div_sts.done) begin
          state_d = bpfa_pkg::ST_RW_INIT;
        end
      end
      bpfa_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = bpfa_pkg::ST_IDLE;
        end
      end
      default: state_d = bpfa_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory/divider controls
  always_comb begin
    clr_d        = clr_q;
    req_d        = req_q;
    count_d      = count_q;
    addr_d       = addr_q;
    len_d        = len_q;
    total_d      = total_q;
    limit_d      = limit_q;
    word_d       = word_q;
    chunk_d      = chunk_q;
    run_d        = run_q;
    hit_d        = hit_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    set_d        = set_q;
    rw_word_d    = rw_word_q;
    end_d        = end_q;
    soff_d       = soff_q;
    eoff_d       = eoff_q;
    prod_d       = prod_q;
    res_d        = res_q;
    stat_d       = stat_q;
    out_addr_d   = out_addr_q;
    out_stat_d   = out_stat_q;
    ram_we       = 1'b0;
    ram_waddr    = rw_word_q;
    ram_wdata    = wr_merge;
    ram_re       = 1'b0;
    ram_raddr    = rw_word_q;
    div_start    = 1'b0;
    div_dividend = DW'(soff_q);
    case (state_q)
      bpfa_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
      end
      bpfa_pkg::ST_IDLE: begin
        if (accept) begin
          req_d   = req_type_i;
          count_d = page_count_i;
          addr_d  = AW'(EW'(address_i));
          len_d   = region_length_i;
          total_d = (TW'(pages_q) < TW'(MAX_PAGES)) ? QW'(pages_q) : QW'(MAX_PAGES);
          res_d   = '0;
          stat_d  = bpfa_pkg::STAT_DONE;
        end
      end
      bpfa_pkg::ST_LIMIT: begin
        limit_d = DW'(total_q) * DW'(PAGE_BYTES);
        word_d  = '0;
        chunk_d = '0;
        run_d   = '0;
        if (req_q != bpfa_pkg::REQ_ALLOC && req_q != bpfa_pkg::REQ_FREE
            && req_q != bpfa_pkg::REQ_RELEASE) begin
          stat_d = bpfa_pkg::STAT_IGN;
        end
      end
      bpfa_pkg::ST_AL_CHK: begin
        if (al_bad) begin
          stat_d = bpfa_pkg::STAT_FAIL;
        end
      end
      bpfa_pkg::ST_AL_RD: begin
        ram_re    = 1'b1;
        ram_raddr = word_q;
      end
      bpfa_pkg::ST_AL_SCAN: begin
        run_d = s_run;
        if (s_hit) begin
          hit_d = s_hitp;
        end else if (s_last) begin
          stat_d = bpfa_pkg::STAT_FAIL;
        end else if (chunk_q == bpfa_pkg::CHUNK_IW'(bpfa_pkg::CHUNKS - 1)) begin
          chunk_d = '0;
          word_d  = word_q + 1'b1;
        end else begin
          chunk_d = chunk_q + 1'b1;
        end
      end
      bpfa_pkg::ST_AL_FOUND: begin
        // run ends at the hit page, so it began count-1 pages earlier
        lo_d  = hit_q + 1'b1 - PGW'(count_w);
        hi_d  = hit_q + 1'b1;
        set_d = 1'b0;
      end
      bpfa_pkg::ST_RW_INIT: begin
        rw_word_d = lo_q[WAW+LW-1:LW];
      end
      bpfa_pkg::ST_RW_RD: begin
        ram_re = 1'b1;
      end
      bpfa_pkg::ST_RW_WR: begin
        ram_we    = 1'b1;
        rw_word_d = rw_word_q + 1'b1;
      end
      bpfa_pkg::ST_AL_MUL: begin
        prod_d = DW'(lo_q) * DW'(PAGE_BYTES);
      end
      bpfa_pkg::ST_AL_ADD: begin
        res_d = base_q + AW'(prod_q);
      end
      bpfa_pkg::ST_FR_OFF: begin
        soff_d = addr_q - base_q;
        if (fr_bad) begin
          stat_d = bpfa_pkg::STAT_IGN;
        end
      end
      bpfa_pkg::ST_FR_CHK: begin
        if (fr_out) begin
          stat_d = bpfa_pkg::STAT_IGN;
        end else begin
          div_start = 1'b1;
        end
      end
      bpfa_pkg::ST_FR_DIV: begin
        if (div_sts.done) begin
          lo_d  = PGW'(div_quot);
          hi_d  = PGW'(div_quot) + 1'b1;
          set_d = 1'b1;
        end
      end
      bpfa_pkg::ST_RL_END: begin
        // end address saturates at the top of the address space
        end_d = (rl_sum > SW'({AW{1'b1}})) ? {AW{1'b1}} : AW'(rl_sum);
      end
      bpfa_pkg::ST_RL_OFF: begin
        eoff_d = XW'(end_q - base_q);
      end
      bpfa_pkg::ST_RL_CLAMP: begin
        soff_d = (addr_q > base_q) ? (addr_q - base_q) : '0;
        if (eoff_q > XW'(limit_q)) begin
          eoff_d = XW'(limit_q);
        end
      end
      bpfa_pkg::ST_RL_EMPTY: begin
        div_start = !rl_empty;
      end
      bpfa_pkg::ST_RL_DIV1: begin
        if (div_sts.done) begin
          lo_d = PGW'(div_quot);
        end
      end
      bpfa_pkg::ST_RL_LEN: begin
        // pages stepped through = ceil((end - start) / page size)
        div_start    = 1'b1;
        div_dividend = DW'(eoff_q - XW'(soff_q)) + DW'(PAGE_BYTES - 1);
      end
      bpfa_pkg::ST_RL_DIV2: begin
        if (div_sts.done) begin
          hi_d  = lo_q + PGW'(div_quot);
          set_d = 1'b1;
        end
      end
      bpfa_pkg::ST_FINISH: begin
        if (out_free) begin
          out_addr_d = bpfa_pkg::ADDR_W'(EW'(res_q));
          out_stat_d = stat_q;
        end
      end
      default: begin
        clr_d = clr_q;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (state_q == bpfa_pkg::ST_FINISH && out_free) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Configuration writes
  always_comb begin
    base_d  = base_q;
    pages_d = pages_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        bpfa_pkg::CFG_BASE:  base_d  = AW'(EW'(cfg_data_i));
        bpfa_pkg::CFG_PAGES: pages_d = cfg_data_i[bpfa_pkg::CNT_W-1:0];
        default:             base_d  = base_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bpfa_pkg::ST_CLEAR;
      clr_q       <= '0;
      base_q      <= '0;
      pages_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      base_q      <= base_d;
      pages_q     <= pages_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    count_q    <= count_d;
    addr_q     <= addr_d;
    len_q      <= len_d;
    total_q    <= total_d;
    limit_q    <= limit_d;
    word_q     <= word_d;
    chunk_q    <= chunk_d;
    run_q      <= run_d;
    hit_q      <= hit_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    set_q      <= set_d;
    rw_word_q  <= rw_word_d;
    end_q      <= end_d;
    soff_q     <= soff_d;
    eoff_q     <= eoff_d;
    prod_q     <= prod_d;
    res_q      <= res_d;
    stat_q     <= stat_d;
    out_addr_q <= out_addr_d;
    out_stat_q <= out_stat_d;
  end

  assign in_stall_o       = (state_q != bpfa_pkg::ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign result_address_o = out_addr_q;
  assign status_o         = out_stat_q;

  // Assertions
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("request taken while sequencer not busy");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == bpfa_pkg::ST_FINISH))
    else $error("result shown without finishing a request");

  a_fail_has_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != bpfa_pkg::STAT_DONE) |-> (result_address_o == '0))
    else $error("failed or ignored request carries an address");

  a_range_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bpfa_pkg::ST_RW_WR) |-> (cur_x <= last_x))
    else $error("bitmap write past the end of the page range");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> (state_q == bpfa_pkg::ST_FR_DIV || state_q == bpfa_pkg::ST_RL_DIV1
                      || state_q == bpfa_pkg::ST_RL_DIV2))
    else $error("divider finished with nobody waiting");

endmodule
